FILE: rtl/dsv_pkg.sv
// Shared types and constants of the date-time string validator.
// No dependencies; the files that use it refer to this package by scoped names.
package dsv_pkg;

	// Character position inside the string, saturating one past the length.
	typedef logic [4:0] pos_t;
	// Two-digit decimal field value.
	typedef logic [6:0] val_t;

	// Expected length and saturation point of the position counter.
	localparam pos_t StrLen = 5'd19;
	localparam pos_t PosSat = 5'd20;

	// Separator positions.
	localparam pos_t PosColon0 = 5'd4;
	localparam pos_t PosColon1 = 5'd7;
	localparam pos_t PosSpace  = 5'd10;
	localparam pos_t PosColon2 = 5'd13;
	localparam pos_t PosColon3 = 5'd16;

	// First position of each two-digit group.
	localparam pos_t PosCentury = 5'd0;
	localparam pos_t PosYy      = 5'd2;
	localparam pos_t PosMonth   = 5'd5;
	localparam pos_t PosDay     = 5'd8;
	localparam pos_t PosHour    = 5'd11;
	localparam pos_t PosMinute  = 5'd14;

	// Character codes.
	localparam logic [7:0] CharColon = 8'h3A;
	localparam logic [7:0] CharSpace = 8'h20;
	localparam logic [7:0] CharZero  = 8'h30;
	localparam logic [7:0] CharNine  = 8'h39;

	// Range limits.
	localparam val_t MonthFirst = 7'd1;
	localparam val_t MonthLast  = 7'd12;
	localparam val_t HourMax    = 7'd23;
	localparam val_t MinSecMax  = 7'd59;
	localparam val_t DayFirst   = 7'd1;
	localparam val_t Days28     = 7'd28;
	localparam val_t Days29     = 7'd29;
	localparam val_t Days30     = 7'd30;
	localparam val_t Days31     = 7'd31;

	// Month numbers with special lengths.
	localparam val_t MonFeb = 7'd2;
	localparam val_t MonApr = 7'd4;
	localparam val_t MonJun = 7'd6;
	localparam val_t MonSep = 7'd9;
	localparam val_t MonNov = 7'd11;

	// Running state of one string. The year is kept as its two digit pairs,
	// which makes the century and leap rules simple bit tests.
	typedef struct packed {
		pos_t position;
		logic format_bad;
		val_t century;
		val_t yy;
		val_t month;
		val_t day;
		val_t hour;
		val_t minute;
		val_t second;
	} fields_t;

	// Decimal accumulate: acc * 10 + d, kept to the field width.
	function automatic val_t acc_digit(input val_t acc, input logic [3:0] d);
		logic [10:0] sum;
		sum = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {7'd0, d};
		return sum[6:0];
	endfunction

endpackage

FILE: rtl/dsv_in_if.sv
// Character channel of the date-time string validator.
// Depends on nothing; carries one character and its end-of-string mark per beat.
interface dsv_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_in;
	logic       last;

	modport source (output valid, output char_in, output last, input ready);
	modport sink (input valid, input char_in, input last, output ready);
endinterface

FILE: rtl/dsv_out_if.sv
// Result channel of the date-time string validator.
// Depends on nothing; carries one validity flag per beat.
interface dsv_out_if;
	logic valid;
	logic ready;
	logic valid_res;

	modport source (output valid, output valid_res, input ready);
	modport sink (input valid, input valid_res, output ready);
endinterface

FILE: rtl/dsv_char_step.sv
// Per-character update of the running string state.
// Depends on dsv_pkg for the state struct, positions and character codes.
module dsv_char_step (
	input  dsv_pkg::fields_t cur,
	input  logic [7:0]       char_in,
	output dsv_pkg::fields_t nxt
);

	logic       is_digit;
	logic [3:0] digit;

	// Digit test; the low nibble of an ASCII digit is its value.
	assign is_digit = (char_in >= dsv_pkg::CharZero) && (char_in <= dsv_pkg::CharNine);
	assign digit    = char_in[3:0];

	// Check the character against its position and fold digits into fields.
	always_comb begin
		nxt = cur;
		if (cur.position < dsv_pkg::StrLen) begin
			case (cur.position) inside
				dsv_pkg::PosColon0, dsv_pkg::PosColon1,
				dsv_pkg::PosColon2, dsv_pkg::PosColon3: begin
					if (char_in != dsv_pkg::CharColon) nxt.format_bad = 1'b1;
				end
				dsv_pkg::PosSpace: begin
					if (char_in != dsv_pkg::CharSpace) nxt.format_bad = 1'b1;
				end
				default: begin
					if (!is_digit) begin
						nxt.format_bad = 1'b1;
					end else begin
						case (cur.position) inside
							[dsv_pkg::PosCentury:dsv_pkg::PosYy - 5'd1]:
								nxt.century = dsv_pkg::acc_digit(cur.century, digit);
							[dsv_pkg::PosYy:dsv_pkg::PosColon0 - 5'd1]:
								nxt.yy = dsv_pkg::acc_digit(cur.yy, digit);
							[dsv_pkg::PosMonth:dsv_pkg::PosColon1 - 5'd1]:
								nxt.month = dsv_pkg::acc_digit(cur.month, digit);
							[dsv_pkg::PosDay:dsv_pkg::PosSpace - 5'd1]:
								nxt.day = dsv_pkg::acc_digit(cur.day, digit);
							[dsv_pkg::PosHour:dsv_pkg::PosColon2 - 5'd1]:
								nxt.hour = dsv_pkg::acc_digit(cur.hour, digit);
							[dsv_pkg::PosMinute:dsv_pkg::PosColon3 - 5'd1]:
								nxt.minute = dsv_pkg::acc_digit(cur.minute, digit);
							default:
								nxt.second = dsv_pkg::acc_digit(cur.second, digit);
						endcase
					end
				end
			endcase
		end
		// Length counter saturates one past the expected length.
		if (cur.position < dsv_pkg::PosSat) nxt.position = cur.position + 5'd1;
	end

endmodule

FILE: rtl/dsv_judge.sv
// Final verdict on a complete string: length, format and calendar ranges.
// Depends on dsv_pkg for the state struct and range limits.
module dsv_judge (
	input  dsv_pkg::fields_t fields,
	output logic             ok
);

	logic          leap;
	dsv_pkg::val_t day_max;
	logic          month_ok;
	logic          time_ok;

	// Gregorian leap rule on the digit pairs: the year is a multiple of four
	// when its last pair is; a century year needs a century divisible by four.
	assign leap = (fields.yy[1:0] == 2'b00) &&
		((fields.yy != 7'd0) || (fields.century[1:0] == 2'b00));

	// Length of the month.
	always_comb begin
		case (fields.month) inside
			dsv_pkg::MonFeb: day_max = leap ? dsv_pkg::Days29 : dsv_pkg::Days28;
			dsv_pkg::MonApr, dsv_pkg::MonJun,
			dsv_pkg::MonSep, dsv_pkg::MonNov: day_max = dsv_pkg::Days30;
			default: day_max = dsv_pkg::Days31;
		endcase
	end

	assign month_ok = (fields.month >= dsv_pkg::MonthFirst) &&
		(fields.month <= dsv_pkg::MonthLast);
	assign time_ok = (fields.hour <= dsv_pkg::HourMax) &&
		(fields.minute <= dsv_pkg::MinSecMax) && (fields.second <= dsv_pkg::MinSecMax);

	// All checks together.
	assign ok = (fields.position == dsv_pkg::StrLen) && !fields.format_bad && month_ok &&
		time_ok && (fields.day >= dsv_pkg::DayFirst) && (fields.day <= day_max);

endmodule

FILE: rtl/datetime_string_validator.sv
// Top level of the date-time string validator: input register, character
// update, verdict logic and result register.
// Depends on dsv_pkg, dsv_in_if, dsv_out_if, dsv_char_step and dsv_judge.
//
// Usage: characters of a YYYY:MM:DD hh:mm:ss string arrive on the chars
// channel, one per beat, with last set on the final character. For every
// string one beat leaves on the results channel; valid_res is 1 when the
// string is exactly 19 characters with digits, separators and calendar
// ranges all correct (leap years per the Gregorian rule), otherwise 0.
// Each character is captured in an input register and processed from it,
// loading the state register and, for a final character, the result
// register; a final character waits while the result register is full
// and not taken. One character is accepted every cycle unless a final one
// so waits; the figure is set by the single update path from the input
// register to the state register. When the receiver stalls, the result
// waits in its register and characters keep flowing until a second final
// character has to wait in the input register; then chars.ready drops.
// Reset empties both registers and clears the string state to zero.
module datetime_string_validator (
	input  logic     clk,
	input  logic     arst_n,
	dsv_in_if.sink   chars,
	dsv_out_if.source results
);

	logic             s1_v_q;
	logic [7:0]       char_s1;
	logic             last_s1;
	logic             out_v_q;
	logic             res_q;
	logic             out_free;
	logic             s1_go;
	logic             s1_fire;
	logic             verdict;
	dsv_pkg::fields_t st_q;
	dsv_pkg::fields_t st_next;

	// Handshake: a non-final character in the input register never waits; a final one needs room.
	assign out_free    = !out_v_q || results.ready;
	assign s1_go       = !last_s1 || out_free;
	assign s1_fire     = s1_v_q && s1_go;
	assign chars.ready = !s1_v_q || s1_go;

	assign results.valid     = out_v_q;
	assign results.valid_res = res_q;

	dsv_char_step u_step (
		.cur     (st_q),
		.char_in (char_s1),
		.nxt     (st_next)
	);

	dsv_judge u_judge (
		.fields (st_next),
		.ok     (verdict)
	);

	// Control: input stage valid, string state and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q  <= 1'b0;
			out_v_q <= 1'b0;
			st_q    <= '0;
		end else begin
			if (chars.ready) s1_v_q <= chars.valid;
			if (s1_fire) begin
				st_q <= last_s1 ? '0 : st_next;
			end
			if (s1_fire && last_s1) out_v_q <= 1'b1;
			else if (results.ready) out_v_q <= 1'b0;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready) begin
			char_s1 <= chars.char_in;
			last_s1 <= chars.last;
		end
		if (s1_fire && last_s1) res_q <= verdict;
	end

endmodule

FILE: rtl/dsv_checker.sv
// Port-level checks of the date-time string validator, bound to the top level.
// Depends on datetime_string_validator for the bind target.
module dsv_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic in_last,
	input logic out_valid,
	input logic out_ready,
	input logic out_res
);

	// A result beat that is not taken holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_res))
		else $error("result beat changed while stalled");

	// With room at the output the block always takes a character.
	a_in_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid || out_ready |-> in_ready)
		else $error("character refused while output has room");

	// An accepted final character reaches the output when the result register has room for it.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && in_last) ##1 (!out_valid || out_ready) |=> out_valid)
		else $error("result missing after final character");

	// No result beat is outstanding right after reset.
	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid)
		else $error("result valid out of reset");

endmodule

bind datetime_string_validator dsv_checker u_dsv_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (chars.valid),
	.in_ready  (chars.ready),
	.in_last   (chars.last),
	.out_valid (results.valid),
	.out_ready (results.ready),
	.out_res   (results.valid_res)
);
